/* rtl/touch_key_window_debounce_to_note_events_unit_defines.svh */
// Assertion macros shared by the touch key checker.
`ifndef TOUCH_KEY_WINDOW_DEBOUNCE_TO_NOTE_EVENTS_UNIT_DEFINES_SVH
`define TOUCH_KEY_WINDOW_DEBOUNCE_TO_NOTE_EVENTS_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TKD_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("tkd check failed");

// next-cycle implication, sampled on clk, off during reset
`define TKD_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("tkd check failed");

`endif

/* rtl/tkd_pkg.sv */
// Package: constants, types and register codes for the touch key note unit.
package tkd_pkg;

    localparam int KEY_COUNT      = 9;
    localparam int WINDOW_SAMPLES = 24;

    localparam int LEVELS_W   = 9;
    localparam int LEVEL_W    = 5;
    localparam int NOTE_W     = 7;
    localparam int KEY_NUM_W  = 4;
    localparam int OFFSET_W   = 7;
    localparam int OFFSETS_W  = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    localparam int POS_W     = $clog2(WINDOW_SAMPLES);
    localparam int CNT_W     = $clog2(WINDOW_SAMPLES + 1);
    localparam int CMP_W     = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
    localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam logic [LEVEL_W-1:0] PRESS_RESET   = LEVEL_W'(14);
    localparam logic [LEVEL_W-1:0] RELEASE_RESET = LEVEL_W'(12);
    localparam logic [NOTE_W-1:0]  BASE_RESET    = NOTE_W'(36);
    localparam logic [NOTE_W-1:0]  NOTE_MAX      = NOTE_W'(127);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS   = 3'd0,
        CFG_RELEASE = 3'd1,
        CFG_BASE    = 3'd2,
        CFG_OFFSETS = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [KEY_COUNT-1:0] change;
        logic [KEY_COUNT-1:0] on;
    } events_t;

endpackage

/* rtl/tkd_keys.sv */
// Per-key sample history, closed-sample counts and press/release decision.
module tkd_keys
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [tkd_pkg::LEVELS_W-1:0]      key_levels,
    input  logic [tkd_pkg::LEVEL_W-1:0]       press_level,
    input  logic [tkd_pkg::LEVEL_W-1:0]       release_level,
    output tkd_pkg::events_t                  events
);

    logic [tkd_pkg::WINDOW_SAMPLES-1:0] hist_reg  [tkd_pkg::KEY_COUNT];
    logic [tkd_pkg::WINDOW_SAMPLES-1:0] hist_next [tkd_pkg::KEY_COUNT];
    logic [tkd_pkg::CNT_W-1:0]          cnt_reg   [tkd_pkg::KEY_COUNT];
    logic [tkd_pkg::CNT_W-1:0]          cnt_next  [tkd_pkg::KEY_COUNT];
    logic [tkd_pkg::KEY_COUNT-1:0]      pressed_reg;
    logic [tkd_pkg::KEY_COUNT-1:0]      pressed_next;
    logic [tkd_pkg::POS_W-1:0]          pos_reg;
    logic [tkd_pkg::POS_W-1:0]          pos_next;

    always_comb
    begin
        logic fresh;
        logic oldest;
        events = '0;
        for (int k = 0; k < tkd_pkg::KEY_COUNT; k++)
        begin
            fresh  = ~key_levels[k];
            oldest = hist_reg[k][pos_reg];
            hist_next[k]          = hist_reg[k];
            hist_next[k][pos_reg] = fresh;
            cnt_next[k] = cnt_reg[k] + tkd_pkg::CNT_W'(fresh) - tkd_pkg::CNT_W'(oldest);
            if (pressed_reg[k])
            begin
                events.change[k] = tkd_pkg::CMP_W'(cnt_next[k]) <
                                   tkd_pkg::CMP_W'(release_level);
            end
            else
            begin
                events.change[k] = tkd_pkg::CMP_W'(cnt_next[k]) >
                                   tkd_pkg::CMP_W'(press_level);
            end
            events.on[k] = ~pressed_reg[k];
        end
        pressed_next = pressed_reg ^ events.change;
        pos_next = (pos_reg == tkd_pkg::POS_W'(tkd_pkg::WINDOW_SAMPLES - 1)) ?
                   '0 : pos_reg + tkd_pkg::POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tkd_pkg::KEY_COUNT; k++)
            begin
                hist_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
            pressed_reg <= '0;
            pos_reg     <= '0;
        end
        else if (accept)
        begin
            for (int k = 0; k < tkd_pkg::KEY_COUNT; k++)
            begin
                hist_reg[k] <= hist_next[k];
                cnt_reg[k]  <= cnt_next[k];
            end
            pressed_reg <= pressed_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

/* rtl/tkd_emit.sv */
// Pending event mask and output register: one note event per cycle while the output is not stalled, key order.
module tkd_emit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  tkd_pkg::events_t                  events,
    input  logic [tkd_pkg::NOTE_W-1:0]        base_note,
    input  logic [tkd_pkg::OFFSETS_W-1:0]     key_offsets,
    input  logic                              out_stall,
    output logic                              busy,
    output logic                              out_valid,
    output logic                              note_on,
    output logic [tkd_pkg::NOTE_W-1:0]        note,
    output logic [tkd_pkg::KEY_NUM_W-1:0]     key_number,
    output logic                              last
);

    logic [tkd_pkg::KEY_COUNT-1:0]  pend_reg;
    logic [tkd_pkg::KEY_COUNT-1:0]  pend_next;
    logic [tkd_pkg::KEY_COUNT-1:0]  on_reg;
    logic [tkd_pkg::KEY_COUNT-1:0]  on_next;
    logic [tkd_pkg::KEY_COUNT-1:0]  low_bit;
    logic [tkd_pkg::KEY_COUNT-1:0]  rest;
    logic [tkd_pkg::KEY_COUNT-1:0]  pend_after;
    logic [tkd_pkg::KEY_IDX_W-1:0]  idx;
    logic [tkd_pkg::OFFSET_W-1:0]   offs [tkd_pkg::KEY_COUNT];
    logic [tkd_pkg::NOTE_W:0]       sum;
    logic                           fire;

    logic                           valid_reg;
    logic                           valid_next;
    logic                           on_out_reg;
    logic [tkd_pkg::NOTE_W-1:0]     note_reg;
    logic [tkd_pkg::KEY_NUM_W-1:0]  key_reg;
    logic                           last_reg;

    always_comb
    begin
        for (int k = 0; k < tkd_pkg::KEY_COUNT; k++)
        begin
            offs[k] = key_offsets[k*tkd_pkg::OFFSET_W +: tkd_pkg::OFFSET_W];
        end
        idx = '0;
        for (int k = tkd_pkg::KEY_COUNT - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
            begin
                idx = tkd_pkg::KEY_IDX_W'(k);
            end
        end
        low_bit    = pend_reg & (~pend_reg + tkd_pkg::KEY_COUNT'(1));
        rest       = pend_reg & ~low_bit;
        fire       = (pend_reg != '0) && (!valid_reg || !out_stall);
        pend_after = fire ? rest : pend_reg;
        busy       = (pend_after != '0);
        pend_next  = accept ? events.change : pend_after;
        on_next    = accept ? events.on : on_reg;
        sum        = {1'b0, base_note} + {1'b0, offs[idx]};
        valid_next = fire ? 1'b1 : (out_stall ? valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        on_reg <= on_next;
        if (fire)
        begin
            on_out_reg <= on_reg[idx];
            note_reg   <= sum[tkd_pkg::NOTE_W] ? tkd_pkg::NOTE_MAX : sum[tkd_pkg::NOTE_W-1:0];
            key_reg    <= tkd_pkg::KEY_NUM_W'(idx);
            last_reg   <= (rest == '0);
        end
    end

    assign out_valid  = valid_reg;
    assign note_on    = on_out_reg;
    assign note       = note_reg;
    assign key_number = key_reg;
    assign last       = last_reg;

endmodule

/* rtl/touch_key_window_debounce_to_note_events_unit.sv */
// The first note event of a tick passes through the pending mask and then the
// output register before it is shown.
// Events leave one per cycle while the output is not stalled; a tick holds the
// input while the single output register drains its pending mask.
// A tick with no change leaves the input free at once.
// Reset clears histories, counts, pressed flags, write position and pending events;
// thresholds go to 14 and 12, base note to 36, key offsets to zero.
module touch_key_window_debounce_to_note_events_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tkd_pkg::LEVELS_W-1:0]      key_levels,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tkd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              note_on,
    output logic [tkd_pkg::NOTE_W-1:0]        note,
    output logic [tkd_pkg::KEY_NUM_W-1:0]     key_number,
    output logic                              last
);

    logic [tkd_pkg::LEVEL_W-1:0]   press_reg;
    logic [tkd_pkg::LEVEL_W-1:0]   release_reg;
    logic [tkd_pkg::NOTE_W-1:0]    base_reg;
    logic [tkd_pkg::OFFSETS_W-1:0] offsets_reg;
    logic                          accept;
    logic                          busy;
    tkd_pkg::events_t              events;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign accept    = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg   <= tkd_pkg::PRESS_RESET;
            release_reg <= tkd_pkg::RELEASE_RESET;
            base_reg    <= tkd_pkg::BASE_RESET;
            offsets_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tkd_pkg::CFG_PRESS:   press_reg   <= cfg_data[tkd_pkg::LEVEL_W-1:0];
                tkd_pkg::CFG_RELEASE: release_reg <= cfg_data[tkd_pkg::LEVEL_W-1:0];
                tkd_pkg::CFG_BASE:    base_reg    <= cfg_data[tkd_pkg::NOTE_W-1:0];
                tkd_pkg::CFG_OFFSETS: offsets_reg <= cfg_data[tkd_pkg::OFFSETS_W-1:0];
                default:              ;
            endcase
        end
    end

    tkd_keys u_keys
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .key_levels    (key_levels),
        .press_level   (press_reg),
        .release_level (release_reg),
        .events        (events)
    );

    tkd_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .events      (events),
        .base_note   (base_reg),
        .key_offsets (offsets_reg),
        .out_stall   (out_stall),
        .busy        (busy),
        .out_valid   (out_valid),
        .note_on     (note_on),
        .note        (note),
        .key_number  (key_number),
        .last        (last)
    );

endmodule

/* rtl/tkd_checker.sv */
// Port-level checker for the touch key note unit, bound to the top level.
`include "touch_key_window_debounce_to_note_events_unit_defines.svh"

module tkd_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              note_on,
    input logic [tkd_pkg::NOTE_W-1:0]        note,
    input logic [tkd_pkg::KEY_NUM_W-1:0]     key_number,
    input logic                              last
);

    // stalled event holds
    `TKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(note) && $stable(key_number) && $stable(note_on) && $stable(last))

    // events of one tick follow without gaps, in rising key order
    `TKD_ASSERT_NEXT(a_tick_order, out_valid && !out_stall && !last, out_valid && (key_number > $past(key_number)))

    `TKD_ASSERT_NOW(a_key_range, out_valid, key_number < tkd_pkg::KEY_NUM_W'(tkd_pkg::KEY_COUNT))

endmodule

bind touch_key_window_debounce_to_note_events_unit tkd_checker u_tkd_checker (.*);
